// ===== sv/lgvt_pkg.sv =====
package lgvt_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam int NUM_CHAN  = 4;
  localparam int TINT_W    = 8;
  localparam int LEN_W     = 16;
  localparam int LEN_SHIFT = 14;
  localparam int SPAN_W    = LEN_W + LEN_SHIFT;
  // blend numerator after dropping the zero fraction bits of the span
  localparam int NUMER_W   = TINT_W + LEN_W;
  localparam int FULL_W    = NUMER_W + LEN_SHIFT;

  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = TINT_W / DIV_BITS_PER_STAGE;

  localparam int DIST_STAGES  = 3;
  localparam int BLEND_STAGES = 2;
  localparam int SCALE_STAGES = 3;
  localparam int PIPE_DEPTH   = DIST_STAGES + BLEND_STAGES + DIV_STAGES + SCALE_STAGES;

  // channel scaling: round(c * t / 255)
  localparam int CHAN_FULL   = 255;
  localparam int CHAN_HALF   = 127;
  localparam int RECIP_MUL   = 257;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_EXTRA = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ABS_MODE    = 4'd0,
    REG_START_X     = 4'd1,
    REG_START_Y     = 4'd2,
    REG_DIR_X       = 4'd3,
    REG_DIR_Y       = 4'd4,
    REG_GRAD_LEN    = 4'd5,
    REG_START_COLOR = 4'd6,
    REG_END_COLOR   = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TINT_START,
    TINT_END,
    TINT_BLEND
  } tint_sel_t;

  // index 3 is red (top byte), index 0 is alpha
  typedef logic [NUM_CHAN-1:0][TINT_W-1:0] rgba_t;

  typedef struct packed {
    logic               abs_mode;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [LEN_W-1:0]   grad_len;
    rgba_t              start_color;
    rgba_t              end_color;
  } cfg_t;

  typedef struct packed {
    tint_sel_t sel;
    logic      last;
  } tag_t;

  localparam cfg_t CFG_RESET = '{
    abs_mode:    1'b0,
    start_x:     16'sd0,
    start_y:     16'sd0,
    dir_x:       16'sd0,
    dir_y:       16'sd0,
    grad_len:    16'd0,
    start_color: {(NUM_CHAN * TINT_W){1'b1}},
    end_color:   {(NUM_CHAN * TINT_W){1'b1}}
  };

endpackage

// ===== sv/linear_gradient_vertex_tint.sv =====
// An accepted input beat passes through the distance, blend, divider and scale stages in order to its result beat.
// Throughput: one vertex per cycle; every stage holds its beat under backpressure
// and accepts a new one whenever the stage after it moves or is empty.
// Depth is set by the dot-product stages, the blend multiply, the 4-stage divider and the scale stages.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
module linear_gradient_vertex_tint #(
  parameter int COORD_BITS   = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lgvt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lgvt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        in_vert_x,
  input  logic signed [COORD_BITS-1:0]        in_vert_y,
  input  logic [CHANNEL_BITS-1:0]             in_red,
  input  logic [CHANNEL_BITS-1:0]             in_green,
  input  logic [CHANNEL_BITS-1:0]             in_blue,
  input  logic [CHANNEL_BITS-1:0]             in_alpha,
  input  logic                                in_last_vertex,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [CHANNEL_BITS-1:0]             out_red,
  output logic [CHANNEL_BITS-1:0]             out_green,
  output logic [CHANNEL_BITS-1:0]             out_blue,
  output logic [CHANNEL_BITS-1:0]             out_alpha,
  output logic                                out_end_of_run
);

  localparam int EXT_W  = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int DIST_W = EXT_W + 1 + 16 + 2;
  localparam int NC     = lgvt_pkg::NUM_CHAN;
  localparam int OCC_W  = $clog2(lgvt_pkg::PIPE_DEPTH + 1);

  typedef logic [NC-1:0][CHANNEL_BITS-1:0] chan_t;

  lgvt_pkg::cfg_t cfg_r, cfg_nxt;

  chan_t                       chan_in, dist_chan, blend_chan, div_chan, scale_chan;
  logic                        dist_valid, dist_ready, dist_last;
  logic signed [DIST_W-1:0]    dist_val;
  logic                        blend_valid, blend_ready;
  logic [NC-1:0][lgvt_pkg::NUMER_W-1:0] blend_num;
  lgvt_pkg::tag_t              blend_tag, div_tag;
  logic                        div_valid, div_ready;
  logic [NC-1:0][lgvt_pkg::TINT_W-1:0]  div_quo;

  logic [OCC_W-1:0] occ_r, occ_nxt;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (lgvt_pkg::cfg_reg_t'(cfg_index))
        lgvt_pkg::REG_ABS_MODE:    cfg_nxt.abs_mode    = cfg_data[0];
        lgvt_pkg::REG_START_X:     cfg_nxt.start_x     = cfg_data[15:0];
        lgvt_pkg::REG_START_Y:     cfg_nxt.start_y     = cfg_data[15:0];
        lgvt_pkg::REG_DIR_X:       cfg_nxt.dir_x       = cfg_data[15:0];
        lgvt_pkg::REG_DIR_Y:       cfg_nxt.dir_y       = cfg_data[15:0];
        lgvt_pkg::REG_GRAD_LEN:    cfg_nxt.grad_len    = cfg_data[lgvt_pkg::LEN_W-1:0];
        lgvt_pkg::REG_START_COLOR: cfg_nxt.start_color = cfg_data;
        lgvt_pkg::REG_END_COLOR:   cfg_nxt.end_color   = cfg_data;
        default:                   cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lgvt_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign chan_in = {in_red, in_green, in_blue, in_alpha};

  lgvt_dist #(
    .COORD_BITS  (COORD_BITS),
    .CHANNEL_BITS(CHANNEL_BITS),
    .DIST_W      (DIST_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .vert_x   (in_vert_x),
    .vert_y   (in_vert_y),
    .chan_in  (chan_in),
    .last_in  (in_last_vertex),
    .out_valid(dist_valid),
    .out_ready(dist_ready),
    .dist_out (dist_val),
    .chan_out (dist_chan),
    .last_out (dist_last)
  );

  lgvt_blend #(
    .CHANNEL_BITS(CHANNEL_BITS),
    .DIST_W      (DIST_W)
  ) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (dist_valid),
    .in_ready (dist_ready),
    .dist_in  (dist_val),
    .chan_in  (dist_chan),
    .last_in  (dist_last),
    .out_valid(blend_valid),
    .out_ready(blend_ready),
    .num_out  (blend_num),
    .tag_out  (blend_tag),
    .chan_out (blend_chan)
  );

  lgvt_div #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .div_len  (cfg_r.grad_len),
    .in_valid (blend_valid),
    .in_ready (blend_ready),
    .num_in   (blend_num),
    .tag_in   (blend_tag),
    .chan_in  (blend_chan),
    .out_valid(div_valid),
    .out_ready(div_ready),
    .quo_out  (div_quo),
    .tag_out  (div_tag),
    .chan_out (div_chan)
  );

  lgvt_scale #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (div_valid),
    .in_ready (div_ready),
    .quo_in   (div_quo),
    .tag_in   (div_tag),
    .chan_in  (div_chan),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .chan_out (scale_chan),
    .last_out (out_end_of_run)
  );

  assign out_red   = scale_chan[3];
  assign out_green = scale_chan[2];
  assign out_blue  = scale_chan[1];
  assign out_alpha = scale_chan[0];

  // beats in flight, for checking only
  always_comb begin
    occ_nxt = occ_r;
    if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(lgvt_pkg::PIPE_DEPTH))
    else $error("more beats in flight than pipeline stages");

  a_out_has_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (occ_r != '0))
    else $error("result beat without a matching input beat");

  a_rst_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_cfg_unlisted: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index > lgvt_pkg::REG_END_COLOR)) |=> $stable(cfg_r))
    else $error("unlisted register index changed configuration");

endmodule

// ===== sv/lgvt_dist.sv =====
module lgvt_dist #(
  parameter int COORD_BITS   = 16,
  parameter int CHANNEL_BITS = 8,
  parameter int DIST_W       = 35
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  lgvt_pkg::cfg_t                                       cfg,
  input  logic                                                 in_valid,
  output logic                                                 in_ready,
  input  logic signed [COORD_BITS-1:0]                         vert_x,
  input  logic signed [COORD_BITS-1:0]                         vert_y,
  input  logic [lgvt_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]      chan_in,
  input  logic                                                 last_in,
  output logic                                                 out_valid,
  input  logic                                                 out_ready,
  output logic signed [DIST_W-1:0]                             dist_out,
  output logic [lgvt_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]      chan_out,
  output logic                                                 last_out
);

  localparam int EXT_W  = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int DIFF_W = EXT_W + 1;
  localparam int PROD_W = DIFF_W + 16;
  localparam int NST    = lgvt_pkg::DIST_STAGES;

  typedef logic [lgvt_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0] chan_t;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;
  chan_t          chan_r [NST];
  logic [NST-1:0] last_r;

  logic signed [DIFF_W-1:0] diff_x_r, diff_y_r, diff_x_nxt, diff_y_nxt;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r, prod_x_nxt, prod_y_nxt;
  logic signed [DIST_W-1:0] sum_v;
  logic signed [DIST_W-1:0] dist_r, dist_nxt;

  assign en[2]    = !vld_r[2] || out_ready;
  assign en[1]    = !vld_r[1] || en[2];
  assign en[0]    = !vld_r[0] || en[1];
  assign in_ready = en[0];

  assign diff_x_nxt = DIFF_W'(vert_x) - DIFF_W'($signed(cfg.start_x));
  assign diff_y_nxt = DIFF_W'(vert_y) - DIFF_W'($signed(cfg.start_y));
  assign prod_x_nxt = PROD_W'(diff_x_r) * PROD_W'($signed(cfg.dir_x));
  assign prod_y_nxt = PROD_W'(diff_y_r) * PROD_W'($signed(cfg.dir_y));
  assign sum_v      = DIST_W'(prod_x_r) + DIST_W'(prod_y_r);
  assign dist_nxt   = (cfg.abs_mode && (sum_v < 0)) ? -sum_v : sum_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      diff_x_r  <= diff_x_nxt;
      diff_y_r  <= diff_y_nxt;
      chan_r[0] <= chan_in;
      last_r[0] <= last_in;
    end
    if (en[1]) begin
      prod_x_r  <= prod_x_nxt;
      prod_y_r  <= prod_y_nxt;
      chan_r[1] <= chan_r[0];
      last_r[1] <= last_r[0];
    end
    if (en[2]) begin
      dist_r    <= dist_nxt;
      chan_r[2] <= chan_r[1];
      last_r[2] <= last_r[1];
    end
  end

  assign out_valid = vld_r[2];
  assign dist_out  = dist_r;
  assign chan_out  = chan_r[2];
  assign last_out  = last_r[2];

endmodule

// ===== sv/lgvt_blend.sv =====
module lgvt_blend #(
  parameter int CHANNEL_BITS = 8,
  parameter int DIST_W       = 35
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  lgvt_pkg::cfg_t                                          cfg,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  logic signed [DIST_W-1:0]                                dist_in,
  input  logic [lgvt_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]         chan_in,
  input  logic                                                    last_in,
  output logic                                                    out_valid,
  input  logic                                                    out_ready,
  output logic [lgvt_pkg::NUM_CHAN-1:0][lgvt_pkg::NUMER_W-1:0]    num_out,
  output lgvt_pkg::tag_t                                          tag_out,
  output logic [lgvt_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]         chan_out
);

  localparam int SPAN_W  = lgvt_pkg::SPAN_W;
  localparam int FULL_W  = lgvt_pkg::FULL_W;
  localparam int NUMER_W = lgvt_pkg::NUMER_W;
  localparam int NC      = lgvt_pkg::NUM_CHAN;

  typedef logic [NC-1:0][CHANNEL_BITS-1:0] chan_t;

  logic [1:0]           vld_r;
  logic [1:0]           en;
  chan_t                chan_r [2];
  lgvt_pkg::tag_t       tag_r  [2];
  lgvt_pkg::tag_t       tag_nxt;

  logic [SPAN_W-1:0]        span;
  logic signed [DIST_W-1:0] span_ext;
  logic [SPAN_W-1:0]        d_r, d_nxt, ld_r, ld_nxt;
  logic [NC-1:0][NUMER_W-1:0] num_r, num_nxt;

  assign en[1]    = !vld_r[1] || out_ready;
  assign en[0]    = !vld_r[0] || en[1];
  assign in_ready = en[0];

  assign span     = {cfg.grad_len, {lgvt_pkg::LEN_SHIFT{1'b0}}};
  assign span_ext = DIST_W'(span);
  assign d_nxt    = dist_in[SPAN_W-1:0];
  assign ld_nxt   = span - d_nxt;

  always_comb begin
    tag_nxt.last = last_in;
    priority if (dist_in <= 0) begin
      tag_nxt.sel = lgvt_pkg::TINT_START;
    end else if (dist_in >= span_ext) begin
      tag_nxt.sel = lgvt_pkg::TINT_END;
    end else begin
      tag_nxt.sel = lgvt_pkg::TINT_BLEND;
    end
  end

  // s*(L-d) + e*d + L/2, then drop the zero low bits of L
  always_comb begin : p_numer
    logic [FULL_W-1:0] full_v;
    for (int k = 0; k < NC; k++) begin
      full_v = FULL_W'(cfg.start_color[k]) * FULL_W'(ld_r)
             + FULL_W'(cfg.end_color[k]) * FULL_W'(d_r)
             + FULL_W'(span >> 1);
      num_nxt[k] = full_v[lgvt_pkg::LEN_SHIFT +: NUMER_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_r       <= d_nxt;
      ld_r      <= ld_nxt;
      tag_r[0]  <= tag_nxt;
      chan_r[0] <= chan_in;
    end
    if (en[1]) begin
      num_r     <= num_nxt;
      tag_r[1]  <= tag_r[0];
      chan_r[1] <= chan_r[0];
    end
  end

  assign out_valid = vld_r[1];
  assign num_out   = num_r;
  assign tag_out   = tag_r[1];
  assign chan_out  = chan_r[1];

endmodule

// ===== sv/lgvt_div.sv =====
module lgvt_div #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic [lgvt_pkg::LEN_W-1:0]                              div_len,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  logic [lgvt_pkg::NUM_CHAN-1:0][lgvt_pkg::NUMER_W-1:0]    num_in,
  input  lgvt_pkg::tag_t                                          tag_in,
  input  logic [lgvt_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]         chan_in,
  output logic                                                    out_valid,
  input  logic                                                    out_ready,
  output logic [lgvt_pkg::NUM_CHAN-1:0][lgvt_pkg::TINT_W-1:0]     quo_out,
  output lgvt_pkg::tag_t                                          tag_out,
  output logic [lgvt_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]         chan_out
);

  localparam int NST     = lgvt_pkg::DIV_STAGES;
  localparam int BPS     = lgvt_pkg::DIV_BITS_PER_STAGE;
  localparam int NC      = lgvt_pkg::NUM_CHAN;
  localparam int NUMER_W = lgvt_pkg::NUMER_W;
  localparam int TINT_W  = lgvt_pkg::TINT_W;

  typedef logic [NC-1:0][CHANNEL_BITS-1:0] chan_t;
  typedef logic [NC-1:0][NUMER_W-1:0]      rem_t;
  typedef logic [NC-1:0][TINT_W-1:0]       quo_t;

  logic [NST-1:0]  vld_r, vld_src, en;
  rem_t            rem_r [NST];
  rem_t            rem_src [NST];
  rem_t            rem_nxt [NST];
  quo_t            quo_r [NST];
  quo_t            quo_src [NST];
  quo_t            quo_nxt [NST];
  lgvt_pkg::tag_t  tag_r [NST];
  lgvt_pkg::tag_t  tag_src [NST];
  chan_t           chan_r [NST];
  chan_t           chan_src [NST];

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_ready;
    for (int g = NST - 2; g >= 0; g--) begin
      en[g] = !vld_r[g] || en[g+1];
    end
  end
  assign in_ready = en[0];

  always_comb begin
    vld_src[0]  = in_valid;
    rem_src[0]  = num_in;
    quo_src[0]  = '0;
    tag_src[0]  = tag_in;
    chan_src[0] = chan_in;
    for (int g = 1; g < NST; g++) begin
      vld_src[g]  = vld_r[g-1];
      rem_src[g]  = rem_r[g-1];
      quo_src[g]  = quo_r[g-1];
      tag_src[g]  = tag_r[g-1];
      chan_src[g] = chan_r[g-1];
    end
  end

  // restoring division, two quotient bits per stage, MSB first
  always_comb begin : p_step
    logic [NUMER_W-1:0] r_v;
    logic [NUMER_W-1:0] trial_v;
    logic [TINT_W-1:0]  q_v;
    for (int g = 0; g < NST; g++) begin
      for (int k = 0; k < NC; k++) begin
        r_v = rem_src[g][k];
        q_v = quo_src[g][k];
        for (int b = 0; b < BPS; b++) begin
          trial_v = NUMER_W'(div_len) << (TINT_W - 1 - g * BPS - b);
          if (r_v >= trial_v) begin
            r_v = r_v - trial_v;
            q_v = {q_v[TINT_W-2:0], 1'b1};
          end else begin
            q_v = {q_v[TINT_W-2:0], 1'b0};
          end
        end
        rem_nxt[g][k] = r_v;
        quo_nxt[g][k] = q_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int g = 0; g < NST; g++) begin
        if (en[g]) vld_r[g] <= vld_src[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NST; g++) begin
      if (en[g]) begin
        rem_r[g]  <= rem_nxt[g];
        quo_r[g]  <= quo_nxt[g];
        tag_r[g]  <= tag_src[g];
        chan_r[g] <= chan_src[g];
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign quo_out   = quo_r[NST-1];
  assign tag_out   = tag_r[NST-1];
  assign chan_out  = chan_r[NST-1];

endmodule

// ===== sv/lgvt_scale.sv =====
module lgvt_scale #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  lgvt_pkg::cfg_t                                          cfg,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  logic [lgvt_pkg::NUM_CHAN-1:0][lgvt_pkg::TINT_W-1:0]     quo_in,
  input  lgvt_pkg::tag_t                                          tag_in,
  input  logic [lgvt_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]         chan_in,
  output logic                                                    out_valid,
  input  logic                                                    out_ready,
  output logic [lgvt_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]         chan_out,
  output logic                                                    last_out
);

  localparam int NC    = lgvt_pkg::NUM_CHAN;
  localparam int Y_W   = CHANNEL_BITS + lgvt_pkg::TINT_W;
  localparam int EST_W = Y_W + lgvt_pkg::RECIP_EXTRA;
  localparam int Q_W   = CHANNEL_BITS + 1;

  logic [2:0] vld_r;
  logic [2:0] en;
  logic [2:0] last_r;

  logic [NC-1:0][Y_W-1:0]          y_r, y_nxt, y2_r;
  logic [NC-1:0][Q_W-1:0]          qest_r, qest_nxt;
  logic [NC-1:0][CHANNEL_BITS-1:0] out_r, out_nxt;

  assign en[2]    = !vld_r[2] || out_ready;
  assign en[1]    = !vld_r[1] || en[2];
  assign en[0]    = !vld_r[0] || en[1];
  assign in_ready = en[0];

  always_comb begin : p_tint
    logic [lgvt_pkg::TINT_W-1:0] tint_v;
    for (int k = 0; k < NC; k++) begin
      unique case (tag_in.sel)
        lgvt_pkg::TINT_START: tint_v = cfg.start_color[k];
        lgvt_pkg::TINT_END:   tint_v = cfg.end_color[k];
        lgvt_pkg::TINT_BLEND: tint_v = quo_in[k];
        default:              tint_v = quo_in[k];
      endcase
      y_nxt[k] = Y_W'(chan_in[k]) * Y_W'(tint_v) + Y_W'(lgvt_pkg::CHAN_HALF);
    end
  end

  // y*257 >> 16 undershoots y/255 by at most one
  always_comb begin : p_est
    logic [EST_W-1:0] prod_v;
    for (int k = 0; k < NC; k++) begin
      prod_v      = EST_W'(y_r[k]) * EST_W'(lgvt_pkg::RECIP_MUL);
      qest_nxt[k] = Q_W'(prod_v >> lgvt_pkg::RECIP_SHIFT);
    end
  end

  always_comb begin : p_fix
    logic [Y_W-1:0] rem_v;
    logic [Q_W-1:0] q_v;
    for (int k = 0; k < NC; k++) begin
      rem_v = y2_r[k] - Y_W'(Y_W'(qest_r[k]) * Y_W'(lgvt_pkg::CHAN_FULL));
      q_v   = qest_r[k];
      if (rem_v >= Y_W'(lgvt_pkg::CHAN_FULL)) begin
        q_v = qest_r[k] + Q_W'(1);
      end
      out_nxt[k] = q_v[CHANNEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y_r       <= y_nxt;
      last_r[0] <= tag_in.last;
    end
    if (en[1]) begin
      qest_r    <= qest_nxt;
      y2_r      <= y_r;
      last_r[1] <= last_r[0];
    end
    if (en[2]) begin
      out_r     <= out_nxt;
      last_r[2] <= last_r[1];
    end
  end

  assign out_valid = vld_r[2];
  assign chan_out  = out_r;
  assign last_out  = last_r[2];

endmodule
